>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implies");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");

`endif

>>> src/bmra_pkg.sv
// ----------------------------------------------------------------------------
// bmra_pkg
// Shared constants for the boot memory range allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmra_pkg;

    localparam int IN_BITS        = 48;
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 48;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_RSV   = 2'd1;
    localparam logic [1:0] MODE_ALLOC = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_NOFIT = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_OVF   = 3'd4;

endpackage

`default_nettype wire

>>> src/bmra_ram.sv
// ----------------------------------------------------------------------------
// bmra_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/boot_memory_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// boot_memory_range_allocator_unit
// First-fit allocator over two sorted range tables (available and reserved).
// ----------------------------------------------------------------------------
// One request carries one command: add an available range, reserve a range,
// or allocate an aligned span. Each command gives exactly one result. The unit
// handles one request at a time and holds o_ready low until the result has
// been formed; a finished result waits in the output register while the next
// request is taken. Add and reserve walk the entries already in the target
// table and write the new range in ahead of the first entry whose base
// is not below its own (one pass over a simple dual-port table RAM that
// inserts and merges in place). Allocate first reduces the alignment to its
// top bit, one bit at a time, then visits each available range and each gap
// between reserved ranges (all through one shared compare/add datapath), then
// inserts into the reserved table on success. Zero length, overflow, a full
// table on add or reserve and the unused mode answer without a table pass.
// Tables start empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module boot_memory_range_allocator_unit #(
    parameter int MAX_BLOCKS = bmra_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = bmra_pkg::ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_mode,
    input  logic [bmra_pkg::IN_BITS-1:0] i_base_address,
    input  logic [bmra_pkg::IN_BITS-1:0] i_length,
    input  logic [bmra_pkg::IN_BITS-1:0] i_alignment,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_status,
    output logic [bmra_pkg::IN_BITS-1:0] o_alloc_address
);

    import bmra_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    // Address arithmetic width: room for ends at the top and alignment carry.
    localparam int EW = ((ADDR_BITS > IN_BITS) ? ADDR_BITS : IN_BITS) + 2;
    localparam int DW = 2 * EW;
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [EW-1:0] TOP  = {{(EW-1){1'b0}}, 1'b1} << ADDR_BITS;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_WTA  = 4'd4;
    localparam logic [3:0] S_GRD  = 4'd5;
    localparam logic [3:0] S_GMS  = 4'd6;
    localparam logic [3:0] S_GAL  = 4'd7;
    localparam logic [3:0] S_GCK  = 4'd8;
    localparam logic [3:0] S_GEND = 4'd9;
    localparam logic [3:0] S_IRD  = 4'd10;
    localparam logic [3:0] S_IWT  = 4'd11;
    localparam logic [3:0] S_ITL  = 4'd12;
    localparam logic [3:0] S_IFN  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    // Control registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_acnt, n_acnt;
    logic [CW-1:0] r_rcnt, n_rcnt;
    logic          r_ovalid, n_ovalid;
    // Request and working registers
    logic [1:0]         r_mode, n_mode;
    logic [IN_BITS-1:0] r_base, n_base;
    logic [IN_BITS-1:0] r_len, n_len;
    logic [IN_BITS-1:0] r_align, n_align;
    logic [IN_BITS-1:0] r_mask, n_mask;
    logic               r_tsel, n_tsel;
    logic               r_isalloc, n_isalloc;
    logic [EW-1:0]      r_nb, n_nb;
    logic [EW-1:0]      r_ne, n_ne;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_w, n_w;
    logic               r_inj, n_inj;
    logic               r_accv, n_accv;
    logic [EW-1:0]      r_accb, n_accb;
    logic [EW-1:0]      r_acce, n_acce;
    logic [CW-1:0]      r_a, n_a;
    logic [CW-1:0]      r_g, n_g;
    logic [EW-1:0]      r_s, n_s;
    logic [EW-1:0]      r_e, n_e;
    logic [EW-1:0]      r_prev, n_prev;
    logic [EW-1:0]      r_ms, n_ms;
    logic [EW-1:0]      r_me, n_me;
    logic [EW-1:0]      r_al, n_al;
    logic [2:0]         r_pstatus, n_pstatus;
    logic [IN_BITS-1:0] r_paddr, n_paddr;
    logic [2:0]         r_ostatus, n_ostatus;
    logic [IN_BITS-1:0] r_oaddr, n_oaddr;

    // Table RAM ports
    logic          w_ins;
    logic          w_we;
    logic [DW-1:0] w_wdata;
    logic [DW-1:0] w_av_rdata, w_rs_rdata;
    logic [IW-1:0] w_av_raddr, w_rs_raddr;
    logic [EW-1:0] w_av_b, w_av_e, w_rs_b, w_rs_e, w_d_b, w_d_e;
    logic [CW-1:0] w_cnt;

    // Shared datapath signals
    logic          w_proc;
    logic          w_take_new;
    logic [EW-1:0] w_eb, w_ee;
    logic [EW-1:0] w_sum, w_gs, w_ge, w_mext, w_lext;
    logic          w_adv;

    assign w_ins = (r_state == S_IRD) || (r_state == S_IWT) ||
                   (r_state == S_ITL) || (r_state == S_IFN);
    assign w_av_raddr = (w_ins && !r_tsel) ? r_j[IW-1:0] : r_a[IW-1:0];
    assign w_rs_raddr = (w_ins && r_tsel)  ? r_j[IW-1:0] : r_g[IW-1:0];

    assign w_av_b = w_av_rdata[DW-1:EW];
    assign w_av_e = w_av_rdata[EW-1:0];
    assign w_rs_b = w_rs_rdata[DW-1:EW];
    assign w_rs_e = w_rs_rdata[EW-1:0];
    assign w_d_b  = r_tsel ? w_rs_b : w_av_b;
    assign w_d_e  = r_tsel ? w_rs_e : w_av_e;
    assign w_cnt  = r_tsel ? r_rcnt : r_acnt;

    assign w_mext = EW'(r_mask);
    assign w_lext = EW'(r_len);
    assign w_sum  = EW'(r_base) + w_lext;
    assign w_gs   = r_prev;
    assign w_ge   = (r_g < r_rcnt) ? w_rs_b : TOP;

    // Insert stream: the new range slides in before the first entry whose
    // base is not below its own.
    assign w_take_new = !r_inj && (r_nb <= w_d_b);
    assign w_proc = (r_state == S_IWT) || ((r_state == S_ITL) && !r_inj);
    assign w_eb   = ((r_state == S_IWT) && !w_take_new) ? w_d_b : r_nb;
    assign w_ee   = ((r_state == S_IWT) && !w_take_new) ? w_d_e : r_ne;

    always_comb begin
        n_state   = r_state;
        n_acnt    = r_acnt;
        n_rcnt    = r_rcnt;
        n_ovalid  = r_ovalid;
        n_mode    = r_mode;
        n_base    = r_base;
        n_len     = r_len;
        n_align   = r_align;
        n_mask    = r_mask;
        n_tsel    = r_tsel;
        n_isalloc = r_isalloc;
        n_nb      = r_nb;
        n_ne      = r_ne;
        n_j       = r_j;
        n_w       = r_w;
        n_inj     = r_inj;
        n_accv    = r_accv;
        n_accb    = r_accb;
        n_acce    = r_acce;
        n_a       = r_a;
        n_g       = r_g;
        n_s       = r_s;
        n_e       = r_e;
        n_prev    = r_prev;
        n_ms      = r_ms;
        n_me      = r_me;
        n_al      = r_al;
        n_pstatus = r_pstatus;
        n_paddr   = r_paddr;
        n_ostatus = r_ostatus;
        n_oaddr   = r_oaddr;
        w_we      = 1'b0;
        w_wdata   = {r_accb, r_acce};
        w_adv     = 1'b0;

        // Drop the result once taken downstream.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        // Merge accumulator: fold overlapping ranges, flush on a gap.
        if (w_proc) begin
            if (!r_accv) begin
                n_accv = 1'b1;
                n_accb = w_eb;
                n_acce = w_ee;
            end else if (w_eb < r_acce) begin
                n_acce = (w_ee > r_acce) ? w_ee : r_acce;
            end else begin
                w_we   = 1'b1;
                n_w    = r_w + 1'b1;
                n_accb = w_eb;
                n_acce = w_ee;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_base  = i_base_address;
                    n_len   = i_length;
                    n_align = i_alignment;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_isalloc = 1'b0;
                n_paddr   = '0;
                n_j       = '0;
                n_w       = '0;
                n_inj     = 1'b0;
                n_accv    = 1'b0;
                n_tsel    = (r_mode != MODE_ADD);
                n_nb      = EW'(r_base);
                n_ne      = w_sum;
                if (r_mode == MODE_NOP) begin
                    n_pstatus = ST_OK;
                    n_state   = S_DONE;
                end else if (r_len == '0) begin
                    n_pstatus = ST_ZERO;
                    n_state   = S_DONE;
                end else if (r_mode == MODE_ALLOC) begin
                    n_mask  = '0;
                    n_state = S_NORM;
                end else if (w_sum > TOP) begin
                    n_pstatus = ST_OVF;
                    n_state   = S_DONE;
                end else if (((r_mode == MODE_ADD) ? r_acnt : r_rcnt) == MAXC) begin
                    n_pstatus = ST_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_NORM: begin
                // Reduce the alignment to its top set bit, one bit a cycle.
                if (r_align > IN_BITS'(1)) begin
                    n_align = r_align >> 1;
                    n_mask  = {r_mask[IN_BITS-2:0], 1'b1};
                end else if (r_acnt == '0) begin
                    n_pstatus = ST_NOFIT;
                    n_state   = S_DONE;
                end else begin
                    n_a     = '0;
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                n_state = S_WTA;
            end
            S_WTA: begin
                n_s     = w_av_b;
                n_e     = w_av_e;
                n_g     = '0;
                n_prev  = '0;
                n_state = S_GRD;
            end
            S_GRD: begin
                n_state = S_GMS;
            end
            S_GMS: begin
                n_ms    = (r_s > w_gs) ? r_s : w_gs;
                n_me    = (r_e < w_ge) ? r_e : w_ge;
                n_prev  = w_rs_e;
                n_state = S_GAL;
            end
            S_GAL: begin
                if (r_ms >= r_me) begin
                    w_adv = 1'b1;
                end else begin
                    n_al    = (r_ms + w_mext) & ~w_mext;
                    n_state = S_GCK;
                end
            end
            S_GCK: begin
                if ((r_al < r_me) && ((r_me - r_al) >= w_lext)) begin
                    n_state = S_GEND;
                end else begin
                    w_adv = 1'b1;
                end
            end
            S_GEND: begin
                if (r_rcnt == MAXC) begin
                    n_pstatus = ST_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_nb      = r_al;
                    n_ne      = r_al + w_lext;
                    n_tsel    = 1'b1;
                    n_isalloc = 1'b1;
                    n_state   = S_IRD;
                end
            end
            S_IRD: begin
                n_state = (r_j < w_cnt) ? S_IWT : S_ITL;
            end
            S_IWT: begin
                // Re-read the same entry after the new range has gone in.
                if (w_take_new) begin
                    n_inj = 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_state = S_IRD;
            end
            S_ITL: begin
                n_state = S_IFN;
            end
            S_IFN: begin
                w_we = 1'b1;
                if (r_tsel) begin
                    n_rcnt = r_w + 1'b1;
                end else begin
                    n_acnt = r_w + 1'b1;
                end
                n_pstatus = ST_OK;
                n_paddr   = r_isalloc ? r_nb[IN_BITS-1:0] : '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_pstatus;
                    n_oaddr   = r_paddr;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next gap, then the next available range.
        if (w_adv) begin
            if (r_g < r_rcnt) begin
                n_g     = r_g + 1'b1;
                n_state = S_GRD;
            end else if ((r_a + 1'b1) < r_acnt) begin
                n_a     = r_a + 1'b1;
                n_state = S_RDA;
            end else begin
                n_pstatus = ST_NOFIT;
                n_state   = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acnt   <= '0;
            r_rcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acnt   <= n_acnt;
            r_rcnt   <= n_rcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_base    <= n_base;
        r_len     <= n_len;
        r_align   <= n_align;
        r_mask    <= n_mask;
        r_tsel    <= n_tsel;
        r_isalloc <= n_isalloc;
        r_nb      <= n_nb;
        r_ne      <= n_ne;
        r_j       <= n_j;
        r_w       <= n_w;
        r_inj     <= n_inj;
        r_accv    <= n_accv;
        r_accb    <= n_accb;
        r_acce    <= n_acce;
        r_a       <= n_a;
        r_g       <= n_g;
        r_s       <= n_s;
        r_e       <= n_e;
        r_prev    <= n_prev;
        r_ms      <= n_ms;
        r_me      <= n_me;
        r_al      <= n_al;
        r_pstatus <= n_pstatus;
        r_paddr   <= n_paddr;
        r_ostatus <= n_ostatus;
        r_oaddr   <= n_oaddr;
    end

    // Available-range table: {base, end} per entry.
    bmra_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_BLOCKS)
    ) u_avail_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_tsel),
        .i_waddr (r_w[IW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_av_raddr),
        .o_rdata (w_av_rdata)
    );

    // Reserved-range table: {base, end} per entry.
    bmra_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_BLOCKS)
    ) u_rsv_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && r_tsel),
        .i_waddr (r_w[IW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_rs_raddr),
        .o_rdata (w_rs_rdata)
    );

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_alloc_address = r_oaddr;

    `ASSERT_ALWAYS(a_acnt_max, i_clk, i_rst_n, r_acnt <= MAXC)
    `ASSERT_ALWAYS(a_rcnt_max, i_clk, i_rst_n, r_rcnt <= MAXC)
    `ASSERT_IMPLIES(a_addr_zero, i_clk, i_rst_n, r_ovalid && (r_ostatus != ST_OK), r_oaddr == '0)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

`default_nettype wire
